// ----- src/lph_pkg.sv -----
`timescale 1ns / 1ps

package lph_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 1024;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned ENTRY_COUNT_W  = 11;
  localparam int unsigned MARK_W         = 2;

  // avalanche mix constants
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic                latch;
    logic                hash_start;
    logic                load_home;
    logic                rd;
    logic                step;
    logic                rec_tomb;
    logic                wr;
    logic                wr_sel_tomb;
    logic [MARK_W-1:0]   wr_mark;
    logic                wr_zero_data;
    logic                clr;
    logic                finish;
    logic [STATUS_W-1:0] status;
    logic                show_data;
    logic                cnt_inc;
    logic                cnt_dec;
  } lph_cmd_t;

  typedef struct packed {
    logic              in_ignore;
    logic [MODE_W-1:0] mode;
    logic              hash_done;
    logic              mark_empty;
    logic              used_match;
    logic              tomb_avail;
    logic              probe_last;
    logic              clr_last;
  } lph_stat_t;

endpackage

// ----- src/lph_hash.sv -----
`timescale 1ns / 1ps

module lph_hash
  import lph_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [63:0]      hash_o
);

  // two rounds, each: three 32x32 partial products, then add and xor-shift
  logic        running_q, running_d;
  logic        round_q, round_d;
  logic [1:0]  phase_q, phase_d;
  logic [63:0] v_q, v_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] prod_q;
  logic [63:0] prod_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] cst;
  logic [63:0] sum;
  logic [63:0] fin;

  assign cst   = round_q ? MIX_C2 : MIX_C1;
  assign mul_a = (phase_q == 2'd2) ? v_q[63:32] : v_q[31:0];
  assign mul_b = (phase_q == 2'd1) ? cst[63:32] : cst[31:0];
  assign prod_d = {32'd0, mul_a} * {32'd0, mul_b};
  assign sum    = acc_q + {prod_q[31:0], 32'd0};
  assign fin    = sum ^ (sum >> MIX_SHIFT);

  assign done_o = running_q && round_q && (phase_q == 2'd3);
  assign hash_o = fin;

  always_comb begin
    running_d = running_q;
    round_d   = round_q;
    phase_d   = phase_q;
    v_d       = v_q;
    acc_d     = acc_q;
    if (start_i) begin
      running_d = 1'b1;
      round_d   = 1'b0;
      phase_d   = 2'd0;
      v_d       = key_i ^ (key_i >> MIX_SHIFT);
    end else if (running_q) begin
      phase_d = phase_q + 2'd1;
      case (phase_q)
        2'd1:    acc_d = prod_q;
        2'd2:    acc_d = sum;
        2'd3: begin
          v_d = fin;
          if (round_q) begin
            running_d = 1'b0;
          end else begin
            round_d = 1'b1;
          end
        end
        default: acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      round_q   <= 1'b0;
      phase_q   <= 2'd0;
    end else begin
      running_q <= running_d;
      round_q   <= round_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

endmodule

// ----- src/lph_datapath.sv -----
`timescale 1ns / 1ps

module lph_datapath
  import lph_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lph_cmd_t                 cmd_i,
  output lph_stat_t                stat_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [KEY_W-1:0]         key_i,
  input  logic [VALUE_W-1:0]       entry_value_i,
  output logic                     valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [VALUE_W-1:0]       found_value_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  logic [MARK_W-1:0]  mark_mem [SLOT_COUNT];
  logic [KEY_W-1:0]   key_mem  [SLOT_COUNT];
  logic [VALUE_W-1:0] data_mem [SLOT_COUNT];

  logic [MODE_W-1:0]  mode_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic [IDX_W-1:0]   idx_q, tomb_q, probe_q, clr_q;
  logic               have_tomb_q;
  logic [MARK_W-1:0]  rd_mark_q;
  logic [KEY_W-1:0]   rd_key_q;
  logic [VALUE_W-1:0] rd_data_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0] found_q;
  logic [ENTRY_COUNT_W-1:0] count_out_q;

  logic               hash_done;
  logic [63:0]        hash;
  logic               mark_we, kd_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [MARK_W-1:0]  wr_mark;
  logic [VALUE_W-1:0] wr_data;
  logic               cur_tomb;

  lph_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.hash_start),
    .key_i  (key_i),
    .done_o (hash_done),
    .hash_o (hash)
  );

  // anything neither empty nor used counts as a tombstone
  assign cur_tomb = (rd_mark_q != MARK_EMPTY) && (rd_mark_q != MARK_USED);

  assign stat_o.in_ignore  = (key_i == '0) ||
                             ((mode_i != MODE_INSERT) && (mode_i != MODE_LOOKUP) &&
                              (mode_i != MODE_REMOVE)) ||
                             ((mode_i == MODE_INSERT) && (entry_value_i == '0));
  assign stat_o.mode       = mode_q;
  assign stat_o.hash_done  = hash_done;
  assign stat_o.mark_empty = (rd_mark_q == MARK_EMPTY);
  assign stat_o.used_match = (rd_mark_q == MARK_USED) && (rd_key_q == key_q);
  assign stat_o.tomb_avail = have_tomb_q || cur_tomb;
  assign stat_o.probe_last = &probe_q;
  assign stat_o.clr_last   = &clr_q;

  assign mark_we = cmd_i.wr || cmd_i.clr;
  assign kd_we   = cmd_i.wr;
  assign wr_addr = cmd_i.clr ? clr_q :
                   (cmd_i.wr_sel_tomb && have_tomb_q) ? tomb_q : idx_q;
  assign wr_mark = cmd_i.clr ? MARK_EMPTY : cmd_i.wr_mark;
  assign wr_data = cmd_i.wr_zero_data ? '0 : val_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec && (count_q != '0)) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[wr_addr] <= wr_mark;
    end
    if (kd_we) begin
      key_mem[wr_addr]  <= key_q;
      data_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_mark_q <= mark_mem[idx_q];
      rd_key_q  <= key_mem[idx_q];
      rd_data_q <= data_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      val_q  <= entry_value_i;
    end
    if (cmd_i.load_home) begin
      idx_q       <= hash[IDX_W-1:0];
      probe_q     <= '0;
      have_tomb_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q   <= idx_q + IDX_W'(1);
      probe_q <= probe_q + IDX_W'(1);
      if (cmd_i.rec_tomb && cur_tomb && !have_tomb_q) begin
        have_tomb_q <= 1'b1;
        tomb_q      <= idx_q;
      end
    end
    if (cmd_i.finish) begin
      status_q    <= cmd_i.status;
      found_q     <= cmd_i.show_data ? rd_data_q : '0;
      count_out_q <= ENTRY_COUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      count_q <= count_d;
      valid_q <= cmd_i.finish;
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign entry_count_o = count_out_q;

endmodule

// ----- src/lph_ctrl.sv -----
`timescale 1ns / 1ps

module lph_ctrl
  import lph_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lph_stat_t stat_i,
  output lph_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (stat_i.in_ignore) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_IGNORED;
          end else begin
            cmd_o.latch      = 1'b1;
            cmd_o.hash_start = 1'b1;
            state_d          = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) begin
          cmd_o.load_home = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (stat_i.mode == MODE_INSERT) begin
          cmd_o.wr_mark = MARK_USED;
          if (stat_i.mark_empty) begin
            // first tombstone passed wins over the empty slot
            cmd_o.wr          = 1'b1;
            cmd_o.wr_sel_tomb = 1'b1;
            cmd_o.cnt_inc     = 1'b1;
            cmd_o.finish      = 1'b1;
            cmd_o.status      = ST_INSERTED;
          end else if (stat_i.used_match) begin
            cmd_o.wr     = 1'b1;
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_UPDATED;
          end else if (stat_i.probe_last) begin
            cmd_o.finish = 1'b1;
            if (stat_i.tomb_avail) begin
              cmd_o.wr          = 1'b1;
              cmd_o.wr_sel_tomb = 1'b1;
              cmd_o.cnt_inc     = 1'b1;
              cmd_o.status      = ST_INSERTED;
            end else begin
              cmd_o.status = ST_FULL;
            end
          end else begin
            cmd_o.step     = 1'b1;
            cmd_o.rec_tomb = 1'b1;
            state_d        = S_READ;
          end
        end else begin
          if (stat_i.used_match) begin
            cmd_o.finish = 1'b1;
            if (stat_i.mode == MODE_REMOVE) begin
              cmd_o.wr           = 1'b1;
              cmd_o.wr_mark      = MARK_TOMB;
              cmd_o.wr_zero_data = 1'b1;
              cmd_o.cnt_dec      = 1'b1;
              cmd_o.status       = ST_REMOVED;
            end else begin
              cmd_o.show_data = 1'b1;
              cmd_o.status    = ST_FOUND;
            end
          end else if (stat_i.mark_empty || stat_i.probe_last) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_NOT_FOUND;
          end else begin
            cmd_o.step = 1'b1;
            state_d    = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

// ----- src/linear_probe_hash_map.sv -----
`timescale 1ns / 1ps

// Open-addressing map, 64-bit keys to 64-bit values, SLOT_COUNT slots, linear
// probing with tombstones. A request is taken when start is high and busy is
// low; its result appears on the result ports for one cycle with valid_o high
// and cannot be held off. An ignored request (null key, unused mode, insert of
// a zero value) answers the cycle after it is taken. Any other request first
// runs the iterative hash unit (one shared 32x32 multiplier, three partial
// products per round), then reads each probed slot through the registered
// read of the slot memory. After reset, busy stays high for a clearing pass
// that marks every slot empty.
module linear_probe_hash_map
  import lph_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [KEY_W-1:0]         key_i,
  input  logic [VALUE_W-1:0]       entry_value_i,
  output logic                     valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [VALUE_W-1:0]       found_value_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o
);

  lph_cmd_t  cmd;
  lph_stat_t stat;

  lph_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  lph_datapath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .entry_value_i(entry_value_i),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .found_value_o(found_value_o),
    .entry_count_o(entry_count_o)
  );

  a_busy_after_walk_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !stat.in_ignore |=> busy)
    else $error("busy not raised after a probing request");

  a_found_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o != ST_FOUND) |-> (found_value_o == '0))
    else $error("found_value non-zero without a hit");

  a_finish_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> valid_o)
    else $error("finished request gave no result strobe");

  a_wr_not_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !cmd.wr && !cmd.finish)
    else $error("slot write or result during clearing pass");

endmodule
